>>> src/cvsfa_pkg.sv
// Package for the chain voltage statistics and frequency advisor.
// Holds field widths, register defaults, state and register codes, the divider
// request and response types, and the frequency lookup. Depends on nothing.
package cvsfa_pkg;

    localparam int CNT_W   = 3;
    localparam int CODE_W  = 15;
    localparam int TOTAL_W = 17;
    localparam int MHZ_W   = 10;
    localparam int SMP_W   = 16;
    localparam int CH_W    = 2;

    localparam logic [CODE_W-1:0]  CODE_MAX   = 15'h7FFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 17'h1FFFF;
    localparam logic [CNT_W-1:0]   FAILED_MAX = 3'd7;

    localparam logic [CNT_W-1:0]  RST_CHAINS_USED = 3'd3;
    localparam logic [CNT_W-1:0]  RST_DEVICES     = 3'd4;
    localparam logic [CODE_W-1:0] RST_VALID_LOW   = 15'd8000;
    localparam logic [CODE_W-1:0] RST_VALID_HIGH  = 15'd12000;

    // Minimum-voltage thresholds in code units and the matching clock choices.
    localparam logic [CODE_W-1:0] THR_575 = 15'd10800;
    localparam logic [CODE_W-1:0] THR_550 = 15'd10400;
    localparam logic [CODE_W-1:0] THR_525 = 15'd10000;
    localparam logic [CODE_W-1:0] THR_500 = 15'd9600;
    localparam logic [CODE_W-1:0] THR_490 = 15'd9328;
    localparam logic [MHZ_W-1:0]  MHZ_575 = 10'd575;
    localparam logic [MHZ_W-1:0]  MHZ_550 = 10'd550;
    localparam logic [MHZ_W-1:0]  MHZ_525 = 10'd525;
    localparam logic [MHZ_W-1:0]  MHZ_500 = 10'd500;
    localparam logic [MHZ_W-1:0]  MHZ_490 = 10'd490;
    localparam logic [MHZ_W-1:0]  MHZ_475 = 10'd475;

    typedef enum logic [1:0] {
        CFG_CHAINS_USED = 2'd0,
        CFG_DEVICES     = 2'd1,
        CFG_VALID_LOW   = 2'd2,
        CFG_VALID_HIGH  = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ACCUM,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               start;
        logic [TOTAL_W-1:0] dividend;
        logic [CNT_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [TOTAL_W-1:0] quotient;
    } div_rsp_t;

    // Clock suggestion from the chain minimum code.
    function automatic logic [MHZ_W-1:0] pick_mhz(input logic [CODE_W-1:0] min_code);
        logic [MHZ_W-1:0] mhz;
        if (min_code >= THR_575) begin
            mhz = MHZ_575;
        end else if (min_code >= THR_550) begin
            mhz = MHZ_550;
        end else if (min_code >= THR_525) begin
            mhz = MHZ_525;
        end else if (min_code >= THR_500) begin
            mhz = MHZ_500;
        end else if (min_code >= THR_490) begin
            mhz = MHZ_490;
        end else begin
            mhz = MHZ_475;
        end
        return mhz;
    endfunction

endpackage

>>> src/cvsfa_div.sv
// Restoring divider for the chain average: one quotient bit per cycle.
// Divides the 17-bit chain total by a 3-bit nonzero divisor.
// Depends on cvsfa_pkg.
module cvsfa_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  cvsfa_pkg::div_req_t req,
    output cvsfa_pkg::div_rsp_t rsp
);
    import cvsfa_pkg::*;

    localparam int STEP_W = $clog2(TOTAL_W);

    logic [TOTAL_W-1:0] work_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   divisor_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W:0]     trial;
    logic [CNT_W:0]     diff;
    logic               fits;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign trial = {rem_reg, work_reg[TOTAL_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = trial >= {1'b0, divisor_reg};

    // Control: step counter, busy and the one-cycle done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(TOTAL_W - 1);
            end else if (busy_reg) begin
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out on top while quotient bits shift in below.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            work_reg    <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end else if (busy_reg) begin
            work_reg <= {work_reg[TOTAL_W-2:0], fits};
            rem_reg  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = work_reg;

endmodule

>>> src/chain_voltage_stats_freq_advisor_core.sv
// Top level of the chain voltage statistics and frequency advisor.
// Holds the sequencer, the running statistics, the per-chain averages and the
// result register. Depends on cvsfa_pkg and cvsfa_div.
//
//   channel   direction  handshake          payload
//   s_*       in         s_valid/s_ready    chain, device, sample code, read ok, last
//   m_*       out        m_valid/m_ready    status, valid flag, chain statistics
//   cfg_*     in         cfg_we             register index and write data
//
// A beat not last in its chain goes through check, accumulate and final steps;
// a rejected beat skips accumulate. A last beat adds prepare and divide, where
// the serial divider produces one quotient bit per cycle for the 17-bit chain
// total, or skips the divide when every device failed and no division is done.
// One beat is in work at a time; s_ready is low until its result is loaded.
// A result waiting on m_ready holds only the final step; the next beat can be
// taken from the cycle after the result register is loaded. Reset is synchronous
// and restores the register defaults and clears all statistics.
module chain_voltage_stats_freq_advisor_core #(
    parameter int MAX_CHAINS = 4
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration write port
    input  logic                                  cfg_we,
    input  logic [1:0]                            cfg_idx,
    input  logic [cvsfa_pkg::CODE_W-1:0]          cfg_wdata,
    // Sample input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [cvsfa_pkg::CH_W-1:0]            s_chain_index,
    input  logic [cvsfa_pkg::CH_W-1:0]            s_device_index,
    input  logic signed [cvsfa_pkg::SMP_W-1:0]    s_sample_code,
    input  logic                                  s_read_ok,
    input  logic                                  s_last_in_chain,
    // Result output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_status,
    output logic                                  m_sample_valid,
    output logic                                  m_chain_done,
    output logic [cvsfa_pkg::TOTAL_W-1:0]         m_total_code,
    output logic [cvsfa_pkg::CODE_W-1:0]          m_average_code,
    output logic [cvsfa_pkg::CODE_W-1:0]          m_min_code,
    output logic [cvsfa_pkg::CODE_W-1:0]          m_max_code,
    output logic [cvsfa_pkg::CNT_W-1:0]           m_failed_count,
    output logic [cvsfa_pkg::MHZ_W-1:0]           m_suggested_mhz
);
    import cvsfa_pkg::*;

    localparam int AVG_IDX_W = (MAX_CHAINS > 1) ? $clog2(MAX_CHAINS) : 1;

    // Configuration registers.
    logic [CNT_W-1:0]  chains_used_reg;
    logic [CNT_W-1:0]  devices_reg;
    logic [CODE_W-1:0] valid_low_reg;
    logic [CODE_W-1:0] valid_high_reg;

    // Captured beat.
    logic [CH_W-1:0]         ch_reg;
    logic [CH_W-1:0]         dev_reg;
    logic signed [SMP_W-1:0] code_reg;
    logic                    ok_reg;
    logic                    last_reg;
    logic                    rej_reg;
    logic                    valid_reg;

    // Running chain statistics and stored averages.
    logic [TOTAL_W-1:0] run_total_reg;
    logic [CODE_W-1:0]  run_min_reg;
    logic [CODE_W-1:0]  run_max_reg;
    logic [CNT_W-1:0]   run_failed_reg;
    logic [CODE_W-1:0]  avg_reg [MAX_CHAINS];

    // Result register.
    logic               m_valid_reg;
    logic               m_status_reg;
    logic               m_sample_valid_reg;
    logic               m_chain_done_reg;
    logic [TOTAL_W-1:0] m_total_reg;
    logic [CODE_W-1:0]  m_average_reg;
    logic [CODE_W-1:0]  m_min_reg;
    logic [CODE_W-1:0]  m_max_reg;
    logic [CNT_W-1:0]   m_failed_reg;
    logic [MHZ_W-1:0]   m_mhz_reg;

    state_t state_reg;
    state_t state_next;
    logic   load_out;
    logic   div_start;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [AVG_IDX_W-1:0]  avg_idx;
    logic                  rej_now;
    logic                  valid_now;
    logic [CODE_W-1:0]     samp_mag;
    logic [TOTAL_W:0]      total_sum;
    logic [CODE_W-1:0]     avg_sat;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chains_used_reg <= RST_CHAINS_USED;
            devices_reg     <= RST_DEVICES;
            valid_low_reg   <= RST_VALID_LOW;
            valid_high_reg  <= RST_VALID_HIGH;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_idx))
                CFG_CHAINS_USED: chains_used_reg <= cfg_wdata[CNT_W-1:0];
                CFG_DEVICES:     devices_reg     <= cfg_wdata[CNT_W-1:0];
                CFG_VALID_LOW:   valid_low_reg   <= cfg_wdata;
                CFG_VALID_HIGH:  valid_high_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Chain rejection and window check on the captured beat.
    assign rej_now   = ({1'b0, ch_reg} >= chains_used_reg) || (32'(ch_reg) >= MAX_CHAINS);
    assign valid_now = ok_reg
                    && ($signed({code_reg[SMP_W-1], code_reg}) > $signed({2'b00, valid_low_reg}))
                    && ($signed({code_reg[SMP_W-1], code_reg}) < $signed({2'b00, valid_high_reg}));
    assign samp_mag  = code_reg[CODE_W-1:0];
    assign total_sum = {1'b0, run_total_reg} + {3'b000, samp_mag};
    assign avg_idx   = AVG_IDX_W'(ch_reg);
    assign avg_sat   = (div_rsp.quotient > {2'b00, CODE_MAX}) ? CODE_MAX
                                                               : div_rsp.quotient[CODE_W-1:0];

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state and strobes.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        load_out   = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = rej_now ? ST_DONE : ST_ACCUM;
            end
            ST_ACCUM: begin
                state_next = last_reg ? ST_PREP : ST_DONE;
            end
            ST_PREP: begin
                if (devices_reg > run_failed_reg) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Capture the accepted beat and its checks.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg   <= s_chain_index;
            dev_reg  <= s_device_index;
            code_reg <= s_sample_code;
            ok_reg   <= s_read_ok;
            last_reg <= s_last_in_chain;
        end
        if (state_reg == ST_CHECK) begin
            rej_reg   <= rej_now;
            valid_reg <= valid_now;
        end
    end

    // Running statistics: cleared on a new scan, then updated with the sample.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_total_reg  <= '0;
            run_min_reg    <= CODE_MAX;
            run_max_reg    <= '0;
            run_failed_reg <= '0;
        end else if (state_reg == ST_CHECK && !rej_now && dev_reg == '0) begin
            run_total_reg  <= '0;
            run_min_reg    <= CODE_MAX;
            run_max_reg    <= '0;
            run_failed_reg <= '0;
        end else if (state_reg == ST_ACCUM) begin
            if (valid_reg) begin
                run_total_reg <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
                if (samp_mag < run_min_reg) begin
                    run_min_reg <= samp_mag;
                end
                if (samp_mag > run_max_reg) begin
                    run_max_reg <= samp_mag;
                end
            end else if (run_failed_reg != FAILED_MAX) begin
                run_failed_reg <= run_failed_reg + 1'b1;
            end
        end
    end

    // Stored chain averages, written when the divider finishes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CHAINS; i++) begin
                avg_reg[i] <= '0;
            end
        end else if (state_reg == ST_DIV && div_rsp.done) begin
            avg_reg[avg_idx] <= avg_sat;
        end
    end

    // Shared divider for the chain average.
    assign div_req.start    = div_start;
    assign div_req.dividend = run_total_reg;
    assign div_req.divisor  = devices_reg - run_failed_reg;

    cvsfa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload; rejected beats and non-final beats zero the statistics.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_status_reg       <= rej_reg;
            m_sample_valid_reg <= !rej_reg && valid_reg;
            m_chain_done_reg   <= !rej_reg && last_reg;
            if (!rej_reg && last_reg) begin
                m_total_reg   <= run_total_reg;
                m_average_reg <= avg_reg[avg_idx];
                m_min_reg     <= run_min_reg;
                m_max_reg     <= run_max_reg;
                m_failed_reg  <= run_failed_reg;
                m_mhz_reg     <= pick_mhz(run_min_reg);
            end else begin
                m_total_reg   <= '0;
                m_average_reg <= '0;
                m_min_reg     <= '0;
                m_max_reg     <= '0;
                m_failed_reg  <= '0;
                m_mhz_reg     <= '0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_sample_valid  = m_sample_valid_reg;
    assign m_chain_done    = m_chain_done_reg;
    assign m_total_code    = m_total_reg;
    assign m_average_code  = m_average_reg;
    assign m_min_code      = m_min_reg;
    assign m_max_code      = m_max_reg;
    assign m_failed_count  = m_failed_reg;
    assign m_suggested_mhz = m_mhz_reg;

    // A rejected beat never reports a valid sample or chain statistics.
    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg |-> !m_sample_valid_reg && !m_chain_done_reg)
        else $error("rejected beat carries sample or chain flags");

    // Any valid sample in a chain keeps the minimum at or below the maximum.
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_chain_done_reg && m_max_reg != '0 |-> m_min_reg <= m_max_reg)
        else $error("chain minimum above chain maximum");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide step");

    // A new result appears only from the final sequencer step.
    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the final step");

endmodule
